### design/ftnru_pkg.sv
// Shared types and constants of the frame table with not-recently-used replacement.
// Used by the controller, the datapath, the top level, the checker and the testbench; depends on nothing else.
package ftnru_pkg;

  // Size of the frame table.
  localparam int FRAMES = 64;
  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // Widths of the item fields.
  localparam int FUNC_W = 2;
  localparam int PAGE_W = 20;
  localparam int OWNER_W = 8;
  localparam int FIDX_W = 6;

  // Width wide enough to compare a frame index against the table size.
  localparam int CMP_W = ((IDX_W > FIDX_W) ? IDX_W : FIDX_W) + 1;

  // Function codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd2;

  // Class above every real class, so that the first frame always wins.
  localparam logic [2:0] CLASS_NONE = 3'd4;

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [OWNER_W-1:0] owner;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic pick;
    logic commit;
    logic update;
  } dp_cmd_t;

  typedef struct packed {
    logic is_alloc;
    logic scan_last;
  } dp_sts_t;

endpackage

### design/frame_table_nru_replacer_top.sv
// Top level of the frame table with not-recently-used victim choice.
// Depends on ftnru_pkg, ftnru_ctrl and ftnru_dp.
//
//   Channel   Handshake                 Ports
//   -------   -----------------------   ------------------------------------------
//   input     start high, busy low      in_func, in_page_number, in_owner_id,
//                                       in_zero_fill, in_frame_index, in_was_write
//   result    out_valid, one cycle      out_granted_frame, out_evicted,
//                                       out_victim_page, out_victim_owner,
//                                       out_clear_page, out_status
//
// An allocate walks the flag registers one frame per cycle through all FRAMES frames,
// then reads the victim's page and owner from the memory in the pick state and
// writes the new entry in the commit state, which also registers the result. Free,
// mark and the unused code register their result in the update state.
// The next item may be accepted in the cycle in which the result is shown.
// Reset is synchronous and active low; it empties the table at once, no sweep.
// The receiver cannot stall: each result is shown for exactly one cycle.
module frame_table_nru_replacer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [ftnru_pkg::FUNC_W-1:0]  in_func,
  input  logic [ftnru_pkg::PAGE_W-1:0]  in_page_number,
  input  logic [ftnru_pkg::OWNER_W-1:0] in_owner_id,
  input  logic                          in_zero_fill,
  input  logic [ftnru_pkg::FIDX_W-1:0]  in_frame_index,
  input  logic                          in_was_write,
  output logic                          out_valid,
  output logic [ftnru_pkg::FIDX_W-1:0]  out_granted_frame,
  output logic                          out_evicted,
  output logic [ftnru_pkg::PAGE_W-1:0]  out_victim_page,
  output logic [ftnru_pkg::OWNER_W-1:0] out_victim_owner,
  output logic                          out_clear_page,
  output logic                          out_status
);

  // The controller only sees two status bits: whether the offered item is an
  // allocate, and whether the scan has reached the last frame.
  ftnru_pkg::dp_cmd_t cmd;
  ftnru_pkg::dp_sts_t sts;

  ftnru_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The datapath holds all frame state and registers each result, so the result
  // ports change only when a new result is strobed.
  ftnru_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_func           (in_func),
    .in_page_number    (in_page_number),
    .in_owner_id       (in_owner_id),
    .in_zero_fill      (in_zero_fill),
    .in_frame_index    (in_frame_index),
    .in_was_write      (in_was_write),
    .out_granted_frame (out_granted_frame),
    .out_evicted       (out_evicted),
    .out_victim_page   (out_victim_page),
    .out_victim_owner  (out_victim_owner),
    .out_clear_page    (out_clear_page),
    .out_status        (out_status)
  );

endmodule

### design/ftnru_ctrl.sv
// Sequencing state machine of the frame table.
// Depends on ftnru_pkg for the command and status structs.
module ftnru_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  ftnru_pkg::dp_sts_t sts,
  output ftnru_pkg::dp_cmd_t cmd,
  output logic               busy,
  output logic               out_valid
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_PICK   = 3'd2;
  localparam logic [2:0] S_COMMIT = 3'd3;
  localparam logic [2:0] S_UPD    = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       valid_r;
  logic       valid_nxt;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = sts.is_alloc ? S_SCAN : S_UPD;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_PICK;
        end
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        valid_nxt  = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        valid_nxt  = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = valid_r;

endmodule

### design/ftnru_dp.sv
// Datapath of the frame table: per-frame flags, page and owner memory,
// the victim scan and the result registers. Depends on ftnru_pkg.
module ftnru_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  ftnru_pkg::dp_cmd_t                cmd,
  output ftnru_pkg::dp_sts_t                sts,
  input  logic [ftnru_pkg::FUNC_W-1:0]      in_func,
  input  logic [ftnru_pkg::PAGE_W-1:0]      in_page_number,
  input  logic [ftnru_pkg::OWNER_W-1:0]     in_owner_id,
  input  logic                              in_zero_fill,
  input  logic [ftnru_pkg::FIDX_W-1:0]      in_frame_index,
  input  logic                              in_was_write,
  output logic [ftnru_pkg::FIDX_W-1:0]      out_granted_frame,
  output logic                              out_evicted,
  output logic [ftnru_pkg::PAGE_W-1:0]      out_victim_page,
  output logic [ftnru_pkg::OWNER_W-1:0]     out_victim_owner,
  output logic                              out_clear_page,
  output logic                              out_status
);

  // Captured item.
  logic [ftnru_pkg::FUNC_W-1:0]  func_r;
  logic [ftnru_pkg::PAGE_W-1:0]  page_r;
  logic [ftnru_pkg::OWNER_W-1:0] owner_r;
  logic                          zfill_r;
  logic [ftnru_pkg::FIDX_W-1:0]  fidx_r;
  logic                          wr_r;

  // Per-frame flags.
  logic [ftnru_pkg::FRAMES-1:0] valid_r;
  logic [ftnru_pkg::FRAMES-1:0] acc_r;
  logic [ftnru_pkg::FRAMES-1:0] dirty_r;

  // Scan state.
  logic [ftnru_pkg::IDX_W-1:0] scan_idx_r;
  logic                        free_found_r;
  logic [ftnru_pkg::IDX_W-1:0] free_slot_r;
  logic [ftnru_pkg::IDX_W-1:0] best_slot_r;
  logic [2:0]                  best_cls_r;
  logic [ftnru_pkg::IDX_W-1:0] sel_slot_r;

  // Page and owner store, read through a register.
  ftnru_pkg::entry_t mem [ftnru_pkg::FRAMES];
  ftnru_pkg::entry_t rd_r;

  logic [1:0]                   cls_cur;
  logic [ftnru_pkg::IDX_W-1:0]  pick_slot;
  logic [ftnru_pkg::CMP_W-1:0]  idx_ext;
  logic                         in_range;
  logic [ftnru_pkg::IDX_W-1:0]  upd_slot;
  logic                         hit;
  logic                         is_free;
  logic                         is_mark;

  assign sts.is_alloc  = (in_func == ftnru_pkg::FUNC_ALLOC);
  assign sts.scan_last = (scan_idx_r == ftnru_pkg::IDX_W'(ftnru_pkg::FRAMES - 1));

  assign cls_cur   = {acc_r[scan_idx_r], dirty_r[scan_idx_r]};
  assign pick_slot = free_found_r ? free_slot_r : best_slot_r;

  assign idx_ext  = ftnru_pkg::CMP_W'(fidx_r);
  assign in_range = (idx_ext < ftnru_pkg::CMP_W'(ftnru_pkg::FRAMES));
  assign upd_slot = idx_ext[ftnru_pkg::IDX_W-1:0];
  assign hit      = in_range && valid_r[upd_slot];
  assign is_free  = (func_r == ftnru_pkg::FUNC_FREE);
  assign is_mark  = (func_r == ftnru_pkg::FUNC_MARK);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      page_r  <= in_page_number;
      owner_r <= in_owner_id;
      zfill_r <= in_zero_fill;
      fidx_r  <= in_frame_index;
      wr_r    <= in_was_write;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      acc_r   <= '0;
      dirty_r <= '0;
    end else if (cmd.commit) begin
      valid_r[sel_slot_r] <= 1'b1;
      acc_r[sel_slot_r]   <= 1'b0;
      dirty_r[sel_slot_r] <= 1'b0;
    end else if (cmd.update && hit) begin
      if (is_free) begin
        valid_r[upd_slot] <= 1'b0;
        acc_r[upd_slot]   <= 1'b0;
        dirty_r[upd_slot] <= 1'b0;
      end else if (is_mark) begin
        acc_r[upd_slot] <= 1'b1;
        if (wr_r) begin
          dirty_r[upd_slot] <= 1'b1;
        end
      end
    end
  end

  // One frame per cycle: first free frame, and first frame of the lowest class.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      free_found_r <= 1'b0;
      best_cls_r   <= ftnru_pkg::CLASS_NONE;
    end else if (cmd.load) begin
      scan_idx_r   <= '0;
      free_found_r <= 1'b0;
      best_cls_r   <= ftnru_pkg::CLASS_NONE;
    end else if (cmd.scan) begin
      scan_idx_r <= scan_idx_r + 1'b1;
      if (!free_found_r && !valid_r[scan_idx_r]) begin
        free_found_r <= 1'b1;
      end
      if ({1'b0, cls_cur} < best_cls_r) begin
        best_cls_r <= {1'b0, cls_cur};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      if (!free_found_r && !valid_r[scan_idx_r]) begin
        free_slot_r <= scan_idx_r;
      end
      if ({1'b0, cls_cur} < best_cls_r) begin
        best_slot_r <= scan_idx_r;
      end
    end
    if (cmd.pick) begin
      sel_slot_r <= pick_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick) begin
      rd_r <= mem[pick_slot];
    end
    if (cmd.commit) begin
      mem[sel_slot_r] <= '{page: page_r, owner: owner_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_granted_frame <= ftnru_pkg::FIDX_W'(sel_slot_r);
      out_evicted       <= !free_found_r;
      out_victim_page   <= free_found_r ? '0 : rd_r.page;
      out_victim_owner  <= free_found_r ? '0 : rd_r.owner;
      out_clear_page    <= zfill_r;
      out_status        <= 1'b0;
    end else if (cmd.update) begin
      out_granted_frame <= fidx_r;
      out_evicted       <= 1'b0;
      out_victim_page   <= '0;
      out_victim_owner  <= '0;
      out_clear_page    <= 1'b0;
      out_status        <= (is_free || is_mark) && !hit;
    end
  end

endmodule

### design/ftnru_chk.sv
// Port-level checker for the frame table, bound to the top level.
// Depends on ftnru_pkg for field widths.
module ftnru_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic                          out_evicted,
  input logic [ftnru_pkg::PAGE_W-1:0]  out_victim_page,
  input logic [ftnru_pkg::OWNER_W-1:0] out_victim_owner,
  input logic                          out_status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item did not make the block busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while the block is still busy");

  a_no_victim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_evicted) |-> (out_victim_page == '0 && out_victim_owner == '0))
    else $error("victim fields set without an eviction");

  a_evict_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> !out_status)
    else $error("eviction reported with an error status");

endmodule

bind frame_table_nru_replacer_top ftnru_chk u_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_evicted      (out_evicted),
  .out_victim_page  (out_victim_page),
  .out_victim_owner (out_victim_owner),
  .out_status       (out_status)
);

### tb/sv/tb_top.sv
// Self-checking testbench for the frame table with not-recently-used replacement.
// Depends on ftnru_pkg and frame_table_nru_replacer_top; holds its own frame table
// predictor and checks every result, field by field, against it.
`timescale 1ns / 100ps

module tb_top;
  import ftnru_pkg::*;

  // The fourth function code does nothing and simply echoes the frame index.
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
  // Longest quiet stretch we tolerate: it covers an allocate plus the longest idle gap
  // of the sender twenty times over, so this leaves a wide margin.
  localparam int STALL_LIMIT = 20 * (FRAMES + 3 + 19);

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [PAGE_W-1:0]  page;
    logic [OWNER_W-1:0] owner;
    logic               zero_fill;
    logic [FIDX_W-1:0]  frame;
    logic               was_write;
  } frame_cmd_t;

  typedef struct {
    logic [FIDX_W-1:0]  granted;
    logic               evicted;
    logic [PAGE_W-1:0]  victim_page;
    logic [OWNER_W-1:0] victim_owner;
    logic               clear;
    logic               status;
  } frame_reply_t;

  // Every input of the block starts at a known value; after that they change only
  // through nonblocking assignments made at the rising edge.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic [FUNC_W-1:0]   in_func = '0;
  logic [PAGE_W-1:0]   in_page_number = '0;
  logic [OWNER_W-1:0]  in_owner_id = '0;
  logic                in_zero_fill = 1'b0;
  logic [FIDX_W-1:0]   in_frame_index = '0;
  logic                in_was_write = 1'b0;
  logic                busy;
  logic                out_valid;
  logic [FIDX_W-1:0]   out_granted_frame;
  logic                out_evicted;
  logic [PAGE_W-1:0]   out_victim_page;
  logic [OWNER_W-1:0]  out_victim_owner;
  logic                out_clear_page;
  logic                out_status;

  // Our own copy of the frame table: occupancy, mapped page, owner, and the
  // referenced and modified bits that make up the replacement class.
  bit                  frm_used [FRAMES];
  logic [PAGE_W-1:0]   frm_page [FRAMES];
  logic [OWNER_W-1:0]  frm_owner [FRAMES];
  bit                  frm_ref [FRAMES];
  bit                  frm_mod [FRAMES];

  // Results we are still waiting for, oldest first.
  frame_reply_t        pending_replies [$];
  frame_reply_t        got_reply;

  int fail_count = 0;
  int quiet_cycles = 0;
  int no_idle_run = 0;
  int n_alloc = 0, n_evict = 0, n_free = 0, n_mark = 0, n_nop = 0, n_empty_hit = 0;
  int evict_class [4] = '{0, 0, 0, 0};

  frame_table_nru_replacer_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_page_number    (in_page_number),
    .in_owner_id       (in_owner_id),
    .in_zero_fill      (in_zero_fill),
    .in_frame_index    (in_frame_index),
    .in_was_write      (in_was_write),
    .out_valid         (out_valid),
    .out_granted_frame (out_granted_frame),
    .out_evicted       (out_evicted),
    .out_victim_page   (out_victim_page),
    .out_victim_owner  (out_victim_owner),
    .out_clear_page    (out_clear_page),
    .out_status        (out_status)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Works out the result of one accepted item and updates the table copy. An
  // allocate prefers the lowest free frame; with the table full it evicts the
  // lowest frame of the lowest class, where class = 2 * referenced + modified.
  function automatic frame_reply_t predict_frame_reply(input frame_cmd_t c);
    frame_reply_t r;
    int slot;
    int best_class;
    int cls;
    r.granted = c.frame;
    r.evicted = 1'b0;
    r.victim_page = '0;
    r.victim_owner = '0;
    r.clear = 1'b0;
    r.status = 1'b0;
    case (c.func)
      FUNC_ALLOC: begin
        n_alloc++;
        slot = -1;
        for (int i = 0; i < FRAMES; i++) begin
          if (!frm_used[i] && slot < 0) slot = i;
        end
        if (slot < 0) begin
          best_class = 4;
          for (int i = 0; i < FRAMES; i++) begin
            cls = 2 * frm_ref[i] + frm_mod[i];
            if (cls < best_class) begin
              best_class = cls;
              slot = i;
            end
          end
          r.evicted = 1'b1;
          r.victim_page = frm_page[slot];
          r.victim_owner = frm_owner[slot];
          n_evict++;
          evict_class[best_class]++;
        end
        frm_used[slot] = 1'b1;
        frm_page[slot] = c.page;
        frm_owner[slot] = c.owner;
        frm_ref[slot] = 1'b0;
        frm_mod[slot] = 1'b0;
        r.granted = FIDX_W'(slot);
        r.clear = c.zero_fill;
      end
      FUNC_FREE: begin
        n_free++;
        if (c.frame < FRAMES && frm_used[c.frame]) begin
          frm_used[c.frame] = 1'b0;
          frm_ref[c.frame] = 1'b0;
          frm_mod[c.frame] = 1'b0;
        end else begin
          r.status = 1'b1;
          n_empty_hit++;
        end
      end
      FUNC_MARK: begin
        n_mark++;
        if (c.frame < FRAMES && frm_used[c.frame]) begin
          frm_ref[c.frame] = 1'b1;
          if (c.was_write) frm_mod[c.frame] = 1'b1;
        end else begin
          r.status = 1'b1;
          n_empty_hit++;
        end
      end
      default: begin
        n_nop++;
      end
    endcase
    return r;
  endfunction

  function automatic frame_cmd_t make_cmd(input logic [FUNC_W-1:0] func,
                                          input logic [PAGE_W-1:0] page,
                                          input logic [OWNER_W-1:0] owner,
                                          input logic zero_fill,
                                          input logic [FIDX_W-1:0] frame,
                                          input logic was_write);
    frame_cmd_t c;
    c.func = func;
    c.page = page;
    c.owner = owner;
    c.zero_fill = zero_fill;
    c.frame = frame;
    c.was_write = was_write;
    return c;
  endfunction

  // An allocate with random content in every field, including the ignored ones.
  function automatic frame_cmd_t random_alloc();
    return make_cmd(FUNC_ALLOC, PAGE_W'($urandom), OWNER_W'($urandom), 1'($urandom),
                    FIDX_W'($urandom), 1'($urandom));
  endfunction

  // Mostly picks an occupied frame, so that frees and marks do real work; now and
  // then any frame at all, which may well be empty.
  function automatic logic [FIDX_W-1:0] pick_frame();
    int base;
    base = $urandom_range(0, FRAMES - 1);
    if ($urandom_range(0, 99) < 85) begin
      for (int k = 0; k < FRAMES; k++) begin
        if (frm_used[(base + k) % FRAMES]) return FIDX_W'((base + k) % FRAMES);
      end
    end
    return FIDX_W'(base);
  endfunction

  // Idle cycles before the next item, drawn at random, with the odd run of
  // back-to-back items.
  function automatic int draw_gap();
    if (no_idle_run > 0) begin
      no_idle_run--;
      return 0;
    end
    if ($urandom_range(0, 11) == 0) begin
      no_idle_run = $urandom_range(4, 24);
      return 0;
    end
    return $urandom_range(0, 19);
  endfunction

  // Presents one item and holds it until the block takes it. Start stays high
  // across back-to-back items, so it is never lowered and raised in one step.
  task automatic send_cmd(input frame_cmd_t c);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= c.func;
    in_page_number <= c.page;
    in_owner_id <= c.owner;
    in_zero_fill <= c.zero_fill;
    in_frame_index <= c.frame;
    in_was_write <= c.was_write;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_replies.push_back(predict_frame_reply(c));
  endtask

  // Stops sending and waits for every outstanding result. It always lets at
  // least one edge pass, so start is never driven twice in one step.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // Short hand-picked sequence: empty-frame errors, the unused function code,
  // field extremes, lowest-free reuse and the clearing of bits on reuse.
  task automatic test_directed();
    send_cmd(make_cmd(FUNC_MARK, '0, '0, 1'b0, '0, 1'b1));
    send_cmd(make_cmd(FUNC_FREE, '0, '0, 1'b0, '1, 1'b0));
    send_cmd(make_cmd(FUNC_NOP, '1, '1, 1'b1, '1, 1'b1));
    send_cmd(make_cmd(FUNC_NOP, '0, '0, 1'b0, '0, 1'b0));
    send_cmd(make_cmd(FUNC_ALLOC, '1, '1, 1'b1, '1, 1'b1));
    send_cmd(make_cmd(FUNC_ALLOC, '0, '0, 1'b0, '0, 1'b0));
    send_cmd(make_cmd(FUNC_ALLOC, 20'h5A5A5, 8'hA5, 1'b1, 6'd21, 1'b0));
    send_cmd(make_cmd(FUNC_MARK, '0, '0, 1'b0, 6'd0, 1'b0));
    send_cmd(make_cmd(FUNC_MARK, '0, '0, 1'b0, 6'd1, 1'b1));
    send_cmd(make_cmd(FUNC_MARK, '1, '1, 1'b1, '1, 1'b1));
    send_cmd(make_cmd(FUNC_FREE, '0, '0, 1'b0, 6'd1, 1'b0));
    send_cmd(make_cmd(FUNC_FREE, '0, '0, 1'b0, 6'd1, 1'b0));
    send_cmd(make_cmd(FUNC_MARK, '0, '0, 1'b0, 6'd1, 1'b1));
    send_cmd(make_cmd(FUNC_ALLOC, 20'hABCDE, 8'h3C, 1'b0, '1, 1'b1));
    send_cmd(make_cmd(FUNC_FREE, '1, '1, 1'b1, 6'd0, 1'b1));
    send_cmd(make_cmd(FUNC_ALLOC, 20'h12345, 8'h81, 1'b1, '0, 1'b0));
    send_cmd(make_cmd(FUNC_MARK, '0, '0, 1'b0, 6'd0, 1'b1));
    send_cmd(make_cmd(FUNC_FREE, '0, '0, 1'b0, 6'd2, 1'b0));
    send_cmd(make_cmd(FUNC_NOP, 20'h0F0F0, 8'h0F, 1'b0, 6'd42, 1'b1));
  endtask

  // Fills the table, then drives it into each replacement class in turn and
  // allocates into it: all referenced and modified first, then all referenced
  // with mixed writes, then freshly reallocated frames that sit in the lowest class.
  task automatic test_victim_classes();
    int to_fill;
    to_fill = 0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!frm_used[i]) to_fill++;
    end
    repeat (to_fill) send_cmd(random_alloc());
    for (int round = 0; round < 2; round++) begin
      for (int i = 0; i < FRAMES; i++) begin
        send_cmd(make_cmd(FUNC_MARK, PAGE_W'($urandom), OWNER_W'($urandom), 1'($urandom),
                          FIDX_W'(i), (round == 0) ? 1'b1 : 1'($urandom)));
      end
      wait_drained();
      repeat (3) send_cmd(random_alloc());
      wait_drained();
    end
    repeat (4) send_cmd(make_cmd(FUNC_FREE, PAGE_W'($urandom), OWNER_W'($urandom),
                                 1'($urandom), pick_frame(), 1'($urandom)));
    repeat (6) send_cmd(random_alloc());
    wait_drained();
  endtask

  // Random mix, weighted towards allocates and marks so that the table stays
  // close to full and evictions keep happening. Halfway through the sender
  // holds off until the block has delivered every result.
  task automatic test_random_mix(input int n_items);
    int pick;
    frame_cmd_t c;
    for (int n = 0; n < n_items; n++) begin
      if (n == n_items / 2) wait_drained();
      pick = $urandom_range(0, 99);
      c = random_alloc();
      if (pick >= 95) c.func = FUNC_NOP;
      else if (pick >= 55) c.func = FUNC_MARK;
      else if (pick >= 40) c.func = FUNC_FREE;
      if (c.func == FUNC_MARK || c.func == FUNC_FREE) c.frame = pick_frame();
      send_cmd(c);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Result checker: every strobed result is compared against the oldest
  // expectation; a result with nothing outstanding is itself a failure.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_replies.size() == 0) begin
        $error("result strobed with no item outstanding");
        fail_count++;
      end else begin
        got_reply = pending_replies.pop_front();
        check_field("granted_frame", 32'(got_reply.granted), 32'(out_granted_frame));
        check_field("evicted", 32'(got_reply.evicted), 32'(out_evicted));
        check_field("victim_page", 32'(got_reply.victim_page), 32'(out_victim_page));
        check_field("victim_owner", 32'(got_reply.victim_owner), 32'(out_victim_owner));
        check_field("clear_page", 32'(got_reply.clear), 32'(out_clear_page));
        check_field("status", 32'(got_reply.status), 32'(out_status));
      end
    end
  end

  // Watchdog: any cycle in which neither an item nor a result is accepted counts
  // towards the limit; a hung block ends the run as a failure.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Main sequence: one reset at the start, the tests in turn, then a drain and a
  // short tail in which any stray result would still be caught.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_victim_classes();
    test_random_mix(375);
    wait_drained();
    repeat (FRAMES + 8) @(posedge clk);
    $display("Covered %0d items: %0d allocates (%0d with eviction), %0d frees, %0d marks, %0d no-ops.",
             n_alloc + n_free + n_mark + n_nop, n_alloc, n_evict, n_free, n_mark, n_nop);
    $display("Victims taken from class 0/2/3: %0d/%0d/%0d; %0d frees or marks hit empty frames.",
             evict_class[0], evict_class[2], evict_class[3], n_empty_hit);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
